// ===== hw/rtl/dtta_pkg.sv =====
package dtta_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int NAME_BYTES = 8;
	localparam int NAME_W = 8 * NAME_BYTES;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] name_key;
		logic [7:0]  channel_in;
		logic [7:0]  ttl_in;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] channel_found;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	// keep the low NAME_BYTES bytes, clear from the first zero byte upward
	function automatic logic [NAME_W-1:0] norm_name(input logic [63:0] key);
		logic [NAME_W-1:0] res;
		logic              live;
		res = '0;
		live = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (key[8*i +: 8] == 8'd0) begin
				live = 1'b0;
			end
			if (live) begin
				res[8*i +: 8] = key[8*i +: 8];
			end
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/device_table_with_ttl_aging_unit.sv =====
// Device table with TTL aging. Each request word (add/refresh, aging tick or
// lookup) scans the whole table through one read port of the entry memory,
// one entry per clock, and gives exactly one response word. After a request
// is accepted it runs through the scan state, a drain state that finishes
// the last compare and a commit state that commits the update and loads the
// response register; req_ready then returns. Words are accepted only in the
// idle cycle that follows, so no new request word enters before the last one
// is through. The commit cycle repeats while the previous response word is
// still held, so a slow receiver stretches the request by the cycles it keeps
// that word waiting. The response register lets the next request enter
// while the previous response waits. The valid bits clear at reset, so the
// table is usable right away.
module device_table_with_ttl_aging_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dtta_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dtta_pkg::rsp_t  rsp
);

	dtta_pkg::state_t state_q, state_nxt;

	logic [dtta_pkg::NAME_W-1:0] name_mem [dtta_pkg::TABLE_ENTRIES];
	logic [7:0]                  chan_mem [dtta_pkg::TABLE_ENTRIES];
	logic [7:0]                  ttl_mem  [dtta_pkg::TABLE_ENTRIES];

	logic [dtta_pkg::TABLE_ENTRIES-1:0] valid_q;

	logic [1:0]                  act_q;
	logic [dtta_pkg::NAME_W-1:0] name_q;
	logic [7:0]                  chan_q;
	logic [7:0]                  ttl_q;

	logic [dtta_pkg::IDX_W-1:0]  cnt_q;
	logic                        pend_s1;
	logic [dtta_pkg::IDX_W-1:0]  idx_s1;
	logic [dtta_pkg::NAME_W-1:0] rd_name_s1;
	logic [7:0]                  rd_chan_s1;
	logic [7:0]                  rd_ttl_s1;

	logic                        hit_q;
	logic                        free_q;
	logic [dtta_pkg::IDX_W-1:0]  hit_idx_q;
	logic [dtta_pkg::IDX_W-1:0]  free_idx_q;
	logic [7:0]                  found_chan_q;

	logic                        rsp_valid_q;
	dtta_pkg::rsp_t              rsp_q;

	logic accept, scan_en, commit_en, commit_go;
	logic ent_vld, name_eq, chan_eq;
	logic is_add, is_tick, is_lookup;
	logic tick_dec, tick_kill, fill, refresh;
	logic                       we_ttl, we_all;
	logic [dtta_pkg::IDX_W-1:0] wr_idx;
	logic [7:0]                 wr_ttl;

	assign is_add = (act_q == dtta_pkg::ACT_ADD);
	assign is_tick = (act_q == dtta_pkg::ACT_TICK);
	assign is_lookup = (act_q == dtta_pkg::ACT_LOOKUP);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dtta_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nxt = dtta_pkg::ST_SCAN;
				end
			end
			dtta_pkg::ST_SCAN: begin
				if (cnt_q == dtta_pkg::LAST_IDX) begin
					state_nxt = dtta_pkg::ST_DRAIN;
				end
			end
			dtta_pkg::ST_DRAIN: begin
				state_nxt = dtta_pkg::ST_COMMIT;
			end
			dtta_pkg::ST_COMMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_nxt = dtta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dtta_pkg::ST_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		req_ready = 1'b0;
		scan_en = 1'b0;
		commit_en = 1'b0;
		case (state_q)
			dtta_pkg::ST_IDLE:   req_ready = 1'b1;
			dtta_pkg::ST_SCAN:   scan_en = 1'b1;
			dtta_pkg::ST_DRAIN:  ;
			dtta_pkg::ST_COMMIT: commit_en = 1'b1;
			default:             ;
		endcase
	end

	assign accept = req_valid && req_ready;
	assign commit_go = commit_en && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtta_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			name_q <= dtta_pkg::norm_name(req.name_key);
			chan_q <= req.channel_in;
			ttl_q <= req.ttl_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= scan_en;
			if (accept) begin
				cnt_q <= '0;
			end else if (scan_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// table read
	always_ff @(posedge clk) begin
		if (scan_en) begin
			idx_s1 <= cnt_q;
			rd_name_s1 <= name_mem[cnt_q];
			rd_chan_s1 <= chan_mem[cnt_q];
			rd_ttl_s1 <= ttl_mem[cnt_q];
		end
	end

	// compare stage
	assign ent_vld = pend_s1 && valid_q[idx_s1];
	assign name_eq = (rd_name_s1 == name_q);
	assign chan_eq = (rd_chan_s1 == chan_q);

	assign tick_dec = is_tick && ent_vld && (rd_ttl_s1 != 8'd0);
	assign tick_kill = is_tick && ent_vld && (rd_ttl_s1 == 8'd0);
	assign refresh = commit_go && is_add && hit_q;
	assign fill = commit_go && is_add && !hit_q && free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (accept) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (pend_s1) begin
			if (ent_vld && name_eq && (chan_eq || is_lookup)) begin
				hit_q <= 1'b1;
			end
			if (!valid_q[idx_s1]) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			if (!hit_q && ent_vld && name_eq && (chan_eq || is_lookup)) begin
				hit_idx_q <= idx_s1;
				found_chan_q <= rd_chan_s1;
			end
			if (!free_q && !valid_q[idx_s1]) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// table write
	assign we_ttl = tick_dec || refresh || fill;
	assign we_all = fill;
	assign wr_idx = commit_en ? (hit_q ? hit_idx_q : free_idx_q) : idx_s1;
	assign wr_ttl = commit_en ? ttl_q : (rd_ttl_s1 - 8'd1);

	always_ff @(posedge clk) begin
		if (we_ttl) begin
			ttl_mem[wr_idx] <= wr_ttl;
		end
		if (we_all) begin
			name_mem[wr_idx] <= name_q;
			chan_mem[wr_idx] <= chan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (tick_kill) begin
			valid_q[idx_s1] <= 1'b0;
		end else if (fill) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	// response word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			rsp_q.ok <= (is_add && (hit_q || free_q)) || (is_lookup && hit_q);
			rsp_q.channel_found <= (is_lookup && hit_q) ? found_chan_q : 8'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
